// File: hdl/csfe_pkg.sv
// ----------------------------------------------------------------------------
// csfe_pkg
// Types, constants and the neighbor offset table shared by the cloth spring
// force evaluation unit.
// ----------------------------------------------------------------------------
`default_nettype none

package csfe_pkg;

  localparam int unsigned STORE_DEPTH = 64;
  localparam int unsigned ADDR_W      = 6;
  localparam int unsigned CNT_W       = 7;
  localparam int unsigned CFG_IDX_W   = 4;
  localparam int unsigned CFG_DATA_W  = 24;
  localparam int unsigned NBR_COUNT   = 12;
  localparam int unsigned NBR_W       = 4;
  localparam int unsigned RC_W        = 5;
  localparam int unsigned D_W         = 25;
  localparam int unsigned QUO_W       = 35;
  localparam int unsigned ACC_W       = 40;

  localparam logic [CFG_IDX_W-1:0] REG_STRUCT_K    = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STRUCT_REST = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SHEAR_K     = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SHEAR_REST  = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FLEX_K      = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FLEX_REST   = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_GRAVITY_Y   = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_DRAG        = 4'd7;

  localparam logic [1:0] KIND_STRUCT = 2'd0;
  localparam logic [1:0] KIND_SHEAR  = 2'd1;
  localparam logic [1:0] KIND_FLEX   = 2'd2;

  typedef struct packed {
    logic signed [23:0] z;
    logic signed [23:0] y;
    logic signed [23:0] x;
  } vec3_t;

  typedef struct packed {
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
    logic signed [23:0] pos_z;
    logic signed [23:0] vel_x;
    logic signed [23:0] vel_y;
    logic signed [23:0] vel_z;
    logic               last_in;
  } in_item_t;

  typedef struct packed {
    logic [5:0]         particle_index;
    logic signed [23:0] dpos_x;
    logic signed [23:0] dpos_y;
    logic signed [23:0] dpos_z;
    logic signed [23:0] force_x;
    logic signed [23:0] force_y;
    logic signed [23:0] force_z;
    logic               last_out;
  } out_item_t;

  typedef struct packed {
    logic                  start;
    logic signed [D_W-1:0] d_x;
    logic signed [D_W-1:0] d_y;
    logic signed [D_W-1:0] d_z;
    logic [15:0]           stiff;
    logic [22:0]           rest;
  } spring_req_t;

  typedef struct packed {
    logic                    busy;
    logic                    done;
    logic signed [QUO_W-1:0] q_x;
    logic signed [QUO_W-1:0] q_y;
    logic signed [QUO_W-1:0] q_z;
  } spring_rsp_t;

  typedef struct packed {
    logic signed [2:0] dr;
    logic signed [2:0] dc;
    logic [1:0]        kind;
  } nbr_t;

  function automatic nbr_t nbr_lookup(input logic [NBR_W-1:0] t);
    nbr_t n;
    n = '0;
    unique case (t)
      4'd0:  n = '{dr: 3'sd0,  dc: 3'sd1,  kind: KIND_STRUCT};
      4'd1:  n = '{dr: 3'sd0,  dc: -3'sd1, kind: KIND_STRUCT};
      4'd2:  n = '{dr: 3'sd1,  dc: 3'sd0,  kind: KIND_STRUCT};
      4'd3:  n = '{dr: -3'sd1, dc: 3'sd0,  kind: KIND_STRUCT};
      4'd4:  n = '{dr: 3'sd1,  dc: 3'sd1,  kind: KIND_SHEAR};
      4'd5:  n = '{dr: 3'sd1,  dc: -3'sd1, kind: KIND_SHEAR};
      4'd6:  n = '{dr: -3'sd1, dc: 3'sd1,  kind: KIND_SHEAR};
      4'd7:  n = '{dr: -3'sd1, dc: -3'sd1, kind: KIND_SHEAR};
      4'd8:  n = '{dr: 3'sd0,  dc: 3'sd2,  kind: KIND_FLEX};
      4'd9:  n = '{dr: 3'sd0,  dc: -3'sd2, kind: KIND_FLEX};
      4'd10: n = '{dr: 3'sd2,  dc: 3'sd0,  kind: KIND_FLEX};
      4'd11: n = '{dr: -3'sd2, dc: 3'sd0,  kind: KIND_FLEX};
      default: n = '0;
    endcase
    return n;
  endfunction

endpackage

`default_nettype wire

// File: hdl/csfe_store.sv
// ----------------------------------------------------------------------------
// csfe_store
// Position and velocity memories with one write port and one registered
// read port each.
// ----------------------------------------------------------------------------
`default_nettype none

module csfe_store (
  input  wire                          clk,
  input  wire                          wr_en,
  input  wire [csfe_pkg::ADDR_W-1:0]   wr_addr,
  input  csfe_pkg::vec3_t              wr_pos,
  input  csfe_pkg::vec3_t              wr_vel,
  input  wire                          rd_en,
  input  wire [csfe_pkg::ADDR_W-1:0]   rd_addr,
  output csfe_pkg::vec3_t              rd_pos,
  output csfe_pkg::vec3_t              rd_vel
);

  csfe_pkg::vec3_t pos_mem [csfe_pkg::STORE_DEPTH];
  csfe_pkg::vec3_t vel_mem [csfe_pkg::STORE_DEPTH];
  csfe_pkg::vec3_t rd_pos_r;
  csfe_pkg::vec3_t rd_vel_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      pos_mem[wr_addr] <= wr_pos;
      vel_mem[wr_addr] <= wr_vel;
    end
    if (rd_en) begin
      rd_pos_r <= pos_mem[rd_addr];
      rd_vel_r <= vel_mem[rd_addr];
    end
  end

  assign rd_pos = rd_pos_r;
  assign rd_vel = rd_vel_r;

endmodule

`default_nettype wire

// File: hdl/csfe_spring.sv
// ----------------------------------------------------------------------------
// csfe_spring
// Sequential spring unit: squares, bit-serial square root, stiffness scaling
// and a bit-serial divider giving the three force quotients of one spring.
// ----------------------------------------------------------------------------
`default_nettype none

module csfe_spring (
  input  wire                   clk,
  input  wire                   rst_n,
  input  csfe_pkg::spring_req_t req,
  output csfe_pkg::spring_rsp_t rsp
);

  localparam int unsigned SQ_W  = 50;
  localparam int unsigned LEN_W = 25;
  localparam int unsigned REM_W = 28;
  localparam int unsigned E_W   = 27;
  localparam int unsigned P_W   = 44;
  localparam int unsigned M_W   = 36;
  localparam int unsigned MD_W  = 61;
  localparam int unsigned DV_W  = 60;

  localparam logic [3:0] SP_IDLE = 4'd0;
  localparam logic [3:0] SP_SQ   = 4'd1;
  localparam logic [3:0] SP_SUM  = 4'd2;
  localparam logic [3:0] SP_SQRT = 4'd3;
  localparam logic [3:0] SP_EMUL = 4'd4;
  localparam logic [3:0] SP_M    = 4'd5;
  localparam logic [3:0] SP_MUL  = 4'd6;
  localparam logic [3:0] SP_DIV  = 4'd7;
  localparam logic [3:0] SP_DONE = 4'd8;

  logic [3:0]                       st_r, st_nxt;
  logic signed [csfe_pkg::D_W-1:0]  d_r [3];
  logic [15:0]                      k_r;
  logic [22:0]                      rest_r;
  logic [SQ_W-2:0]                  sqp_r [3];
  logic [SQ_W-1:0]                  x_r;
  logic [REM_W-1:0]                 rem_r;
  logic [LEN_W-1:0]                 root_r;
  logic [5:0]                       it_r;
  logic signed [P_W-1:0]            prod_r;
  logic signed [M_W-1:0]            m_r;
  logic [1:0]                       c_r;
  logic                             neg_r;
  logic [DV_W-1:0]                  dvd_r;
  logic [LEN_W:0]                   dr_r;
  logic signed [csfe_pkg::QUO_W-1:0] quo_r [2];

  logic [REM_W-1:0]        rem_t, trial;
  logic signed [E_W-1:0]   e_w;
  logic signed [MD_W-1:0]  md_w;
  logic [DV_W-1:0]         mag_w;
  logic [LEN_W:0]          dr_t;
  logic signed [csfe_pkg::QUO_W-1:0] qpos_w;

  always_comb begin
    rem_t  = {rem_r[REM_W-3:0], x_r[SQ_W-1 -: 2]};
    trial  = {1'b0, root_r, 2'b01};
    e_w    = $signed({2'b00, root_r}) - $signed({4'b0000, rest_r});
    md_w   = m_r * d_r[c_r];
    mag_w  = md_w[MD_W-1] ? DV_W'(-md_w) : DV_W'(md_w);
    dr_t   = {dr_r[LEN_W-1:0], dvd_r[DV_W-1]};
    qpos_w = $signed(dvd_r[csfe_pkg::QUO_W-1:0]);
  end

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      SP_IDLE: if (req.start) st_nxt = SP_SQ;
      SP_SQ:   st_nxt = SP_SUM;
      SP_SUM:  st_nxt = SP_SQRT;
      SP_SQRT: if (it_r == 6'(LEN_W - 1)) st_nxt = SP_EMUL;
      SP_EMUL: st_nxt = (root_r == '0) ? SP_DONE : SP_M;
      SP_M:    st_nxt = SP_MUL;
      SP_MUL:  st_nxt = SP_DIV;
      SP_DIV:  begin
        if (it_r == 6'(DV_W - 1)) st_nxt = (c_r == 2'd2) ? SP_DONE : SP_MUL;
      end
      SP_DONE: st_nxt = SP_IDLE;
      default: st_nxt = SP_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= SP_IDLE;
    else        st_r <= st_nxt;
  end

  always_ff @(posedge clk) begin
    unique case (st_r)
      SP_IDLE: begin
        d_r[0] <= req.d_x;
        d_r[1] <= req.d_y;
        d_r[2] <= req.d_z;
        k_r    <= req.stiff;
        rest_r <= req.rest;
      end
      SP_SQ: begin
        for (int i = 0; i < 3; i++) begin
          sqp_r[i] <= (SQ_W-1)'(d_r[i] * d_r[i]);
        end
      end
      SP_SUM: begin
        x_r    <= SQ_W'(sqp_r[0]) + SQ_W'(sqp_r[1]) + SQ_W'(sqp_r[2]);
        rem_r  <= '0;
        root_r <= '0;
        it_r   <= '0;
        for (int i = 0; i < 2; i++) quo_r[i] <= '0;
      end
      SP_SQRT: begin
        if (rem_t >= trial) begin
          rem_r  <= rem_t - trial;
          root_r <= {root_r[LEN_W-2:0], 1'b1};
        end else begin
          rem_r  <= rem_t;
          root_r <= {root_r[LEN_W-2:0], 1'b0};
        end
        x_r  <= {x_r[SQ_W-3:0], 2'b00};
        it_r <= it_r + 6'd1;
      end
      SP_EMUL: begin
        prod_r <= $signed({1'b0, k_r}) * e_w;
        c_r    <= '0;
        it_r   <= '0;
      end
      SP_M: begin
        if (prod_r[P_W-1]) m_r <= M_W'((prod_r + P_W'(255)) >>> 8);
        else               m_r <= M_W'(prod_r >>> 8);
      end
      SP_MUL: begin
        neg_r <= md_w[MD_W-1];
        dvd_r <= mag_w;
        dr_r  <= '0;
        it_r  <= '0;
      end
      SP_DIV: begin
        if (dr_t >= {1'b0, root_r}) begin
          dr_r  <= dr_t - {1'b0, root_r};
          dvd_r <= {dvd_r[DV_W-2:0], 1'b1};
        end else begin
          dr_r  <= dr_t;
          dvd_r <= {dvd_r[DV_W-2:0], 1'b0};
        end
        it_r <= it_r + 6'd1;
        if (it_r == 6'(DV_W - 1) && c_r != 2'd2) c_r <= c_r + 2'd1;
      end
      SP_DONE: ;
      default: ;
    endcase
    if (st_r == SP_MUL && it_r != '0) begin
      quo_r[c_r[1]] <= neg_r ? -qpos_w : qpos_w;
    end
  end

  always_comb begin
    rsp.busy = (st_r != SP_IDLE);
    rsp.done = (st_r == SP_DONE);
    rsp.q_x  = quo_r[0];
    rsp.q_y  = quo_r[1];
    rsp.q_z  = (root_r == '0) ? '0 : (neg_r ? -qpos_w : qpos_w);
  end

endmodule

`default_nettype wire

// File: hdl/cloth_spring_force_eval_unit.sv
// ----------------------------------------------------------------------------
// cloth_spring_force_eval_unit
// Mass-spring cloth force evaluation over a stored particle grid.
// ----------------------------------------------------------------------------
// Particles enter on the in_ channel, one request per particle in row-major
// order, and are written to the position and velocity memories at one per
// cycle. The request marked last_in closes the load; in_ready then stays low
// until the final result has been placed in the output register. One result
// per loaded particle follows on the out_ channel, in index order, with
// last_out on the final one.
// Each result takes a self read (S_SELF_RD, S_SELF_WT), then for each of the
// up to twelve neighbors a memory read (S_NB_CHK, S_NB_WT) and a run of the
// shared spring unit (25 square root steps and three bit-serial divides),
// then S_FIN for gravity and drag and S_OUT for the output register.
// Particles 0 and GRID_COLS-1 skip the neighbors and S_FIN. A neighbor
// outside the grid or not yet loaded is skipped without a memory read.
// The output register lets the next particle compute while a result waits;
// a stalled receiver holds the sequencer only when the register is full.
// The user must write configuration on the cfg_ channel only while the block
// is idle; not enforced. Reset clears the load count, sets config defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module cloth_spring_force_eval_unit #(
  parameter int unsigned GRID_COLS = 8,
  parameter int unsigned GRID_ROWS = 8
) (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire                                 in_valid,
  output logic                                in_ready,
  input  csfe_pkg::in_item_t                  in_data,
  output logic                                out_valid,
  input  wire                                 out_ready,
  output csfe_pkg::out_item_t                 out_data,
  input  wire                                 cfg_valid,
  output logic                                cfg_ready,
  input  wire [csfe_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire [csfe_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int unsigned NUM_CELLS = GRID_ROWS * GRID_COLS;
  localparam logic signed [csfe_pkg::ACC_W-1:0] Q_MAX = 40'sd8388607;
  localparam logic signed [csfe_pkg::ACC_W-1:0] Q_MIN = -40'sd8388608;

  localparam logic [2:0] S_LOAD    = 3'd0;
  localparam logic [2:0] S_SELF_RD = 3'd1;
  localparam logic [2:0] S_SELF_WT = 3'd2;
  localparam logic [2:0] S_NB_CHK  = 3'd3;
  localparam logic [2:0] S_NB_WT   = 3'd4;
  localparam logic [2:0] S_SPR     = 3'd5;
  localparam logic [2:0] S_FIN     = 3'd6;
  localparam logic [2:0] S_OUT     = 3'd7;

  logic [2:0]                          st_r, st_nxt;
  logic [csfe_pkg::CNT_W-1:0]          count_r;
  logic [csfe_pkg::ADDR_W-1:0]         p_r;
  logic signed [csfe_pkg::RC_W-1:0]    row_r, col_r;
  logic [csfe_pkg::NBR_W-1:0]          t_r;
  csfe_pkg::vec3_t                     self_pos_r, self_vel_r;
  logic signed [csfe_pkg::ACC_W-1:0]   acc_r [3];
  logic                                out_valid_r;
  csfe_pkg::out_item_t                 out_data_r;

  logic [15:0] ks_r, kh_r, kf_r, drag_r;
  logic [22:0] rs_r, rh_r, rf_r;
  logic [23:0] grav_r;

  csfe_pkg::vec3_t      rd_pos, rd_vel, wr_pos, wr_vel;
  logic                 rd_en, wr_en;
  logic [csfe_pkg::ADDR_W-1:0] rd_addr;
  csfe_pkg::spring_req_t spr_req;
  csfe_pkg::spring_rsp_t spr_rsp;

  csfe_pkg::nbr_t                     nbr_w;
  logic signed [csfe_pkg::RC_W-1:0]   r2_w, c2_w;
  logic [csfe_pkg::CNT_W-1:0]         q_w;
  logic                               nb_ok_w;
  logic                               last_p_w;
  logic                               out_free_w;
  logic                               load_acc_w;
  logic signed [40:0]                 dprod_w [3];
  logic signed [32:0]                 drag_w [3];
  logic signed [23:0]                 vel_w [3];
  logic signed [23:0]                 frc_w [3];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ks_r   <= 16'd256;
      rs_r   <= 23'd32768;
      kh_r   <= 16'd256;
      rh_r   <= 23'd46341;
      kf_r   <= 16'd256;
      rf_r   <= 23'd65536;
      grav_r <= 24'd0;
      drag_r <= 16'd0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        csfe_pkg::REG_STRUCT_K:    ks_r   <= cfg_data[15:0];
        csfe_pkg::REG_STRUCT_REST: rs_r   <= cfg_data[22:0];
        csfe_pkg::REG_SHEAR_K:     kh_r   <= cfg_data[15:0];
        csfe_pkg::REG_SHEAR_REST:  rh_r   <= cfg_data[22:0];
        csfe_pkg::REG_FLEX_K:      kf_r   <= cfg_data[15:0];
        csfe_pkg::REG_FLEX_REST:   rf_r   <= cfg_data[22:0];
        csfe_pkg::REG_GRAVITY_Y:   grav_r <= cfg_data;
        csfe_pkg::REG_DRAG:        drag_r <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  assign in_ready   = (st_r == S_LOAD);
  assign load_acc_w = in_valid && in_ready;
  assign wr_en      = load_acc_w && (count_r < csfe_pkg::CNT_W'(NUM_CELLS));
  assign wr_pos     = '{z: in_data.pos_z, y: in_data.pos_y, x: in_data.pos_x};
  assign wr_vel     = '{z: in_data.vel_z, y: in_data.vel_y, x: in_data.vel_x};

  csfe_store u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (count_r[csfe_pkg::ADDR_W-1:0]),
    .wr_pos  (wr_pos),
    .wr_vel  (wr_vel),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_pos  (rd_pos),
    .rd_vel  (rd_vel)
  );

  always_comb begin
    nbr_w   = csfe_pkg::nbr_lookup(t_r);
    r2_w    = row_r + csfe_pkg::RC_W'(nbr_w.dr);
    c2_w    = col_r + csfe_pkg::RC_W'(nbr_w.dc);
    q_w     = csfe_pkg::CNT_W'(int'(r2_w) * int'(GRID_COLS) + int'(c2_w));
    nb_ok_w = (r2_w >= 0) && (r2_w < csfe_pkg::RC_W'(GRID_ROWS)) &&
              (c2_w >= 0) && (c2_w < csfe_pkg::RC_W'(GRID_COLS)) &&
              (q_w < count_r);
    last_p_w   = ({1'b0, p_r} + csfe_pkg::CNT_W'(1)) == count_r;
    out_free_w = !out_valid_r || out_ready;
  end

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = p_r;
    if (st_r == S_SELF_RD) begin
      rd_en = 1'b1;
    end else if (st_r == S_NB_CHK && nb_ok_w) begin
      rd_en   = 1'b1;
      rd_addr = q_w[csfe_pkg::ADDR_W-1:0];
    end
  end

  always_comb begin
    spr_req.start = (st_r == S_NB_WT);
    spr_req.d_x   = csfe_pkg::D_W'(self_pos_r.x) - csfe_pkg::D_W'(rd_pos.x);
    spr_req.d_y   = csfe_pkg::D_W'(self_pos_r.y) - csfe_pkg::D_W'(rd_pos.y);
    spr_req.d_z   = csfe_pkg::D_W'(self_pos_r.z) - csfe_pkg::D_W'(rd_pos.z);
    priority case (nbr_w.kind)
      csfe_pkg::KIND_STRUCT: begin spr_req.stiff = ks_r; spr_req.rest = rs_r; end
      csfe_pkg::KIND_SHEAR:  begin spr_req.stiff = kh_r; spr_req.rest = rh_r; end
      default:               begin spr_req.stiff = kf_r; spr_req.rest = rf_r; end
    endcase
  end

  csfe_spring u_spring (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (spr_req),
    .rsp   (spr_rsp)
  );

  always_comb begin
    vel_w[0] = self_vel_r.x;
    vel_w[1] = self_vel_r.y;
    vel_w[2] = self_vel_r.z;
    for (int i = 0; i < 3; i++) begin
      dprod_w[i] = $signed({1'b0, drag_r}) * vel_w[i];
      if (dprod_w[i][40]) drag_w[i] = 33'((dprod_w[i] + 41'sd255) >>> 8);
      else                drag_w[i] = 33'(dprod_w[i] >>> 8);
      if (acc_r[i] > Q_MAX)      frc_w[i] = 24'sh7FFFFF;
      else if (acc_r[i] < Q_MIN) frc_w[i] = -24'sh800000;
      else                       frc_w[i] = acc_r[i][23:0];
    end
  end

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      S_LOAD:    if (load_acc_w && in_data.last_in) st_nxt = S_SELF_RD;
      S_SELF_RD: st_nxt = S_SELF_WT;
      S_SELF_WT: begin
        if (p_r == '0 || p_r == csfe_pkg::ADDR_W'(GRID_COLS - 1)) st_nxt = S_OUT;
        else st_nxt = S_NB_CHK;
      end
      S_NB_CHK: begin
        if (nb_ok_w) st_nxt = S_NB_WT;
        else if (t_r == csfe_pkg::NBR_W'(csfe_pkg::NBR_COUNT - 1)) st_nxt = S_FIN;
      end
      S_NB_WT:   st_nxt = S_SPR;
      S_SPR: begin
        if (spr_rsp.done) begin
          st_nxt = (t_r == csfe_pkg::NBR_W'(csfe_pkg::NBR_COUNT - 1)) ? S_FIN : S_NB_CHK;
        end
      end
      S_FIN:     st_nxt = S_OUT;
      S_OUT: begin
        if (out_free_w) st_nxt = last_p_w ? S_LOAD : S_SELF_RD;
      end
      default:   st_nxt = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_LOAD;
      count_r     <= '0;
      p_r         <= '0;
      row_r       <= '0;
      col_r       <= '0;
      t_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (wr_en) count_r <= count_r + csfe_pkg::CNT_W'(1);
      if (st_r == S_OUT && out_free_w) out_valid_r <= 1'b1;
      else if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      if (st_r == S_SELF_WT) t_r <= '0;
      if ((st_r == S_NB_CHK && !nb_ok_w) || (st_r == S_SPR && spr_rsp.done)) begin
        t_r <= t_r + csfe_pkg::NBR_W'(1);
      end
      if (st_r == S_OUT && out_free_w) begin
        if (last_p_w) begin
          count_r <= '0;
          p_r     <= '0;
          row_r   <= '0;
          col_r   <= '0;
        end else begin
          p_r <= p_r + csfe_pkg::ADDR_W'(1);
          if (col_r == csfe_pkg::RC_W'(GRID_COLS - 1)) begin
            col_r <= '0;
            row_r <= row_r + csfe_pkg::RC_W'(1);
          end else begin
            col_r <= col_r + csfe_pkg::RC_W'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (st_r == S_SELF_WT) begin
      self_pos_r <= rd_pos;
      self_vel_r <= rd_vel;
      for (int i = 0; i < 3; i++) acc_r[i] <= '0;
    end
    if (st_r == S_SPR && spr_rsp.done) begin
      acc_r[0] <= acc_r[0] - csfe_pkg::ACC_W'(spr_rsp.q_x);
      acc_r[1] <= acc_r[1] - csfe_pkg::ACC_W'(spr_rsp.q_y);
      acc_r[2] <= acc_r[2] - csfe_pkg::ACC_W'(spr_rsp.q_z);
    end
    if (st_r == S_FIN) begin
      acc_r[0] <= acc_r[0] - csfe_pkg::ACC_W'(drag_w[0]);
      acc_r[1] <= acc_r[1] - csfe_pkg::ACC_W'(drag_w[1])
                  + csfe_pkg::ACC_W'($signed(grav_r));
      acc_r[2] <= acc_r[2] - csfe_pkg::ACC_W'(drag_w[2]);
    end
    if (st_r == S_OUT && out_free_w) begin
      out_data_r.particle_index <= p_r;
      out_data_r.dpos_x   <= (p_r == '0) ? '0 : self_vel_r.x;
      out_data_r.dpos_y   <= (p_r == '0) ? '0 : self_vel_r.y;
      out_data_r.dpos_z   <= (p_r == '0) ? '0 : self_vel_r.z;
      out_data_r.force_x  <= frc_w[0];
      out_data_r.force_y  <= frc_w[1];
      out_data_r.force_z  <= frc_w[2];
      out_data_r.last_out <= last_p_w;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= csfe_pkg::CNT_W'(NUM_CELLS))
    else $error("load count beyond grid size");

  a_nb_read_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_NB_CHK && rd_en) |-> (q_w < count_r))
    else $error("neighbor read of an entry that was not loaded");

  a_spring_idle_start: assert property (@(posedge clk) disable iff (!rst_n)
    spr_req.start |-> !spr_rsp.busy)
    else $error("spring unit started while busy");

  a_no_load_in_compute: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_SPR) |-> !wr_en)
    else $error("memory write during force evaluation");
`endif

endmodule

`default_nettype wire
